// ----- sv/arpc_pkg.sv -----
package arpc_pkg;

  localparam int CacheEntries = 64;
  localparam int RequestSlots = 16;

  localparam logic [15:0] TimeoutReset = 16'd15;
  localparam logic [7:0] ResendReset = 8'd1;
  localparam logic [3:0] TriesReset = 4'd5;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUEUE = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_LOOKUP = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_QUEUE = 3'd2,
    KIND_RESOLVED = 3'd3,
    KIND_SEND = 3'd4,
    KIND_GIVEUP = 3'd5,
    KIND_DONE = 3'd6
  } kind_t;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RESEND = 2'd1;
  localparam logic [1:0] REG_TRIES = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PSCAN,
    ST_PSCAN_SETTLE,
    ST_PSCAN_WAIT,
    ST_CSCAN,
    ST_CSCAN_SETTLE,
    ST_CSCAN_WAIT,
    ST_AGE,
    ST_AGE_WAIT,
    ST_SLOT,
    ST_SLOT_SCAN,
    ST_SLOT_WAIT,
    ST_SLOT_ACT,
    ST_DONE
  } state_t;

endpackage

// ----- sv/arpc_cache_mem.sv -----
module arpc_cache_mem #(
  parameter int Entries = arpc_pkg::CacheEntries
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(Entries)-1:0] waddr,
  input  logic [31:0]                wip,
  input  logic [47:0]                wmac,
  input  logic [31:0]                wadded,
  input  logic [$clog2(Entries)-1:0] raddr,
  output logic [31:0]                rip,
  output logic [47:0]                rmac,
  output logic [31:0]                radded
);

  logic [111:0] mem [Entries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wip, wmac, wadded};
    end
    {rip, rmac, radded} <= mem[raddr];
  end

endmodule

// ----- sv/arpc_pend_mem.sv -----
module arpc_pend_mem #(
  parameter int Slots = arpc_pkg::RequestSlots
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Slots)-1:0] waddr,
  input  logic [31:0]              wip,
  input  logic [31:0]              wsent,
  input  logic [3:0]               wtries,
  input  logic [$clog2(Slots)-1:0] raddr,
  output logic [31:0]              rip,
  output logic [31:0]              rsent,
  output logic [3:0]               rtries
);

  logic [67:0] mem [Slots];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wip, wsent, wtries};
    end
    {rip, rsent, rtries} <= mem[raddr];
  end

endmodule

// ----- sv/arp_cache_with_request_retry.sv -----
// Command-driven ARP cache. Raise start with a command while busy is low. Results are
// strobed on result_valid for one cycle each and cannot be stalled; the final result of a
// request has last set, and busy is already low in that cycle. The tables, each with one read
// port and one write port, are walked one entry per cycle: a lookup scans the cache, a queue
// the request slots, an insert the request slots and then the cache, and a tick ages every
// cache entry and then scans the whole cache for each valid request. Configuration writes are
// always ready and must be issued only while busy is low.
module arp_cache_with_request_retry #(
  parameter int CACHE_ENTRIES = arpc_pkg::CacheEntries,
  parameter int REQUEST_SLOTS = arpc_pkg::RequestSlots
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] ip_addr,
  input  logic [47:0] mac_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic [2:0]  kind,
  output logic        hit,
  output logic [47:0] mac_out,
  output logic [31:0] ip_out,
  output logic        pending_found,
  output logic        stored,
  output logic        last
);

  localparam int CW = $clog2(CACHE_ENTRIES);
  localparam int PW = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
  localparam int PD = (REQUEST_SLOTS > 1) ? REQUEST_SLOTS : 2;

  arpc_pkg::state_t state, state_next;

  logic [15:0] cache_timeout;
  logic [7:0]  resend_interval;
  logic [3:0]  max_tries;
  logic [31:0] seconds_now;

  logic [CACHE_ENTRIES-1:0] entry_valid;
  logic [PD-1:0]            pending_valid;

  arpc_pkg::cmd_t cmd;
  logic [31:0] ip;
  logic [47:0] mac;

  logic [CW:0] cidx;
  logic [PW:0] pidx;
  logic [CW-1:0] c_rd;
  logic [PW-1:0] p_rd;

  logic          c_found;
  logic          c_free_found;
  logic [CW-1:0] c_free;
  logic          p_found;
  logic [PW-1:0] p_hitix;
  logic          p_free_found;
  logic [PW-1:0] p_free;
  logic          vcheck;
  logic [CW-1:0] vcheck_ix;
  logic          pvcheck;
  logic [PW-1:0] pvcheck_ix;

  logic [31:0] c_rip, c_radded, p_rip, p_rsent;
  logic [47:0] c_rmac, hit_mac;
  logic [3:0]  p_rtries;
  logic        c_we, p_we;
  logic [CW-1:0] c_waddr;
  logic [PW-1:0] p_waddr;
  logic [31:0] p_wsent;
  logic [3:0]  p_wtries;
  logic [31:0] p_wip;

  logic [31:0] age;
  logic [31:0] since;
  logic c_last, p_last;

  assign c_last = (cidx[CW-1:0] == CW'(CACHE_ENTRIES - 1));
  assign p_last = (pidx[PW-1:0] == PW'(REQUEST_SLOTS - 1));
  assign c_rd = cidx[CW-1:0];
  assign p_rd = pidx[PW-1:0];
  assign age = seconds_now - c_radded;
  assign since = seconds_now - p_rsent;
  assign cfg_ready = 1'b1;
  assign busy = (state != arpc_pkg::ST_IDLE);

  arpc_cache_mem #(.Entries(CACHE_ENTRIES)) u_cache (
    .clk, .we(c_we), .waddr(c_waddr), .wip(ip), .wmac(mac), .wadded(seconds_now),
    .raddr(c_rd), .rip(c_rip), .rmac(c_rmac), .radded(c_radded)
  );

  arpc_pend_mem #(.Slots(PD)) u_pend (
    .clk, .we(p_we), .waddr(p_waddr), .wip(p_wip), .wsent(p_wsent), .wtries(p_wtries),
    .raddr(p_rd), .rip(p_rip), .rsent(p_rsent), .rtries(p_rtries)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      arpc_pkg::ST_IDLE: begin
        if (start) begin
          unique case (arpc_pkg::cmd_t'(command))
            arpc_pkg::CMD_LOOKUP: state_next = arpc_pkg::ST_CSCAN;
            arpc_pkg::CMD_TICK:   state_next = arpc_pkg::ST_AGE;
            default:              state_next = arpc_pkg::ST_PSCAN;
          endcase
        end
      end
      arpc_pkg::ST_PSCAN: if (p_last) state_next = arpc_pkg::ST_PSCAN_SETTLE;
      arpc_pkg::ST_PSCAN_SETTLE: state_next = arpc_pkg::ST_PSCAN_WAIT;
      arpc_pkg::ST_PSCAN_WAIT: begin
        if (cmd == arpc_pkg::CMD_QUEUE) state_next = arpc_pkg::ST_IDLE;
        else state_next = arpc_pkg::ST_CSCAN;
      end
      arpc_pkg::ST_CSCAN: if (c_last) state_next = arpc_pkg::ST_CSCAN_SETTLE;
      arpc_pkg::ST_CSCAN_SETTLE: state_next = arpc_pkg::ST_CSCAN_WAIT;
      arpc_pkg::ST_CSCAN_WAIT: state_next = arpc_pkg::ST_IDLE;
      arpc_pkg::ST_AGE: if (c_last) state_next = arpc_pkg::ST_AGE_WAIT;
      arpc_pkg::ST_AGE_WAIT: state_next = arpc_pkg::ST_SLOT;
      arpc_pkg::ST_SLOT: begin
        if (pidx > (PW+1)'(REQUEST_SLOTS - 1)) state_next = arpc_pkg::ST_DONE;
        else if (pending_valid[p_rd]) state_next = arpc_pkg::ST_SLOT_SCAN;
      end
      arpc_pkg::ST_SLOT_SCAN: if (c_last) state_next = arpc_pkg::ST_SLOT_WAIT;
      arpc_pkg::ST_SLOT_WAIT: state_next = arpc_pkg::ST_SLOT_ACT;
      arpc_pkg::ST_SLOT_ACT: state_next = arpc_pkg::ST_SLOT;
      arpc_pkg::ST_DONE: state_next = arpc_pkg::ST_IDLE;
      default: state_next = arpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    c_we = 1'b0;
    c_waddr = c_free;
    p_we = 1'b0;
    p_waddr = p_free;
    p_wip = ip;
    p_wsent = seconds_now;
    p_wtries = '0;
    if (state == arpc_pkg::ST_PSCAN_WAIT && cmd == arpc_pkg::CMD_QUEUE &&
        !p_found && p_free_found) begin
      p_we = 1'b1;
    end
    if (state == arpc_pkg::ST_CSCAN_WAIT && cmd == arpc_pkg::CMD_INSERT && c_free_found) begin
      c_we = 1'b1;
    end
    if (state == arpc_pkg::ST_SLOT_ACT && !c_found && (p_rtries == 4'd0 ||
        since > {24'd0, resend_interval}) && p_rtries < max_tries) begin
      p_we = 1'b1;
      p_waddr = p_rd;
      p_wip = p_rip;
      p_wtries = p_rtries + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpc_pkg::ST_IDLE;
      cache_timeout <= arpc_pkg::TimeoutReset;
      resend_interval <= arpc_pkg::ResendReset;
      max_tries <= arpc_pkg::TriesReset;
      seconds_now <= '0;
      entry_valid <= '0;
      pending_valid <= '0;
      result_valid <= 1'b0;
      cidx <= '0;
      pidx <= '0;
      vcheck <= 1'b0;
      pvcheck <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      vcheck <= 1'b0;
      pvcheck <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          arpc_pkg::REG_TIMEOUT: cache_timeout <= cfg_data;
          arpc_pkg::REG_RESEND:  resend_interval <= cfg_data[7:0];
          arpc_pkg::REG_TRIES:   max_tries <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (c_we) entry_valid[c_waddr] <= 1'b1;
      unique case (state)
        arpc_pkg::ST_IDLE: begin
          cidx <= '0;
          pidx <= '0;
          c_found <= 1'b0;
          c_free_found <= 1'b0;
          p_found <= 1'b0;
          p_free_found <= 1'b0;
          if (start) begin
            cmd <= arpc_pkg::cmd_t'(command);
            ip <= ip_addr;
            mac <= mac_addr;
            if (arpc_pkg::cmd_t'(command) == arpc_pkg::CMD_TICK) seconds_now <= seconds_now + 32'd1;
          end
        end
        arpc_pkg::ST_PSCAN: begin
          pvcheck <= 1'b1;
          pvcheck_ix <= p_rd;
          if (!p_last) pidx <= pidx + 1'b1;
          if (!pending_valid[p_rd] && !p_free_found) begin
            p_free_found <= 1'b1;
            p_free <= p_rd;
          end
        end
        arpc_pkg::ST_PSCAN_WAIT: begin
          if (p_we) pending_valid[p_free] <= 1'b1;
          if (cmd == arpc_pkg::CMD_INSERT && p_found) pending_valid[p_hitix] <= 1'b0;
          if (cmd == arpc_pkg::CMD_QUEUE) begin
            result_valid <= 1'b1;
            kind <= arpc_pkg::KIND_QUEUE;
            hit <= 1'b0;
            mac_out <= '0;
            ip_out <= ip;
            pending_found <= p_found;
            stored <= !p_found && p_free_found;
            last <= 1'b1;
          end
          cidx <= '0;
        end
        arpc_pkg::ST_CSCAN, arpc_pkg::ST_SLOT_SCAN: begin
          vcheck <= 1'b1;
          vcheck_ix <= c_rd;
          if (!c_last) cidx <= cidx + 1'b1;
          if (!entry_valid[c_rd] && !c_free_found) begin
            c_free_found <= 1'b1;
            c_free <= c_rd;
          end
        end
        arpc_pkg::ST_CSCAN_WAIT: begin
          result_valid <= 1'b1;
          kind <= (cmd == arpc_pkg::CMD_LOOKUP) ? arpc_pkg::KIND_LOOKUP : arpc_pkg::KIND_INSERT;
          hit <= (cmd == arpc_pkg::CMD_LOOKUP) && c_found;
          mac_out <= ((cmd == arpc_pkg::CMD_LOOKUP) && c_found) ? hit_mac : '0;
          ip_out <= ip;
          pending_found <= (cmd == arpc_pkg::CMD_INSERT) && p_found;
          stored <= (cmd == arpc_pkg::CMD_INSERT) && c_free_found;
          last <= 1'b1;
        end
        arpc_pkg::ST_AGE: begin
          vcheck <= 1'b1;
          vcheck_ix <= c_rd;
          if (!c_last) cidx <= cidx + 1'b1;
        end
        arpc_pkg::ST_AGE_WAIT: pidx <= '0;
        arpc_pkg::ST_SLOT: begin
          cidx <= '0;
          c_found <= 1'b0;
          if (pidx <= (PW+1)'(REQUEST_SLOTS - 1) && !pending_valid[p_rd]) pidx <= pidx + 1'b1;
        end
        arpc_pkg::ST_SLOT_ACT: begin
          pidx <= pidx + 1'b1;
          if (c_found) begin
            pending_valid[p_rd] <= 1'b0;
            result_valid <= 1'b1;
            kind <= arpc_pkg::KIND_RESOLVED;
            hit <= 1'b1;
            mac_out <= hit_mac;
          end else if (p_rtries == 4'd0 || since > {24'd0, resend_interval}) begin
            result_valid <= 1'b1;
            hit <= 1'b0;
            mac_out <= '0;
            if (p_rtries >= max_tries) begin
              pending_valid[p_rd] <= 1'b0;
              kind <= arpc_pkg::KIND_GIVEUP;
            end else begin
              kind <= arpc_pkg::KIND_SEND;
            end
          end
          ip_out <= p_rip;
          pending_found <= 1'b0;
          stored <= 1'b0;
          last <= 1'b0;
        end
        arpc_pkg::ST_DONE: begin
          result_valid <= 1'b1;
          kind <= arpc_pkg::KIND_DONE;
          hit <= 1'b0;
          mac_out <= '0;
          ip_out <= '0;
          pending_found <= 1'b0;
          stored <= 1'b0;
          last <= 1'b1;
        end
        default: ;
      endcase
      if (vcheck) begin
        if (state == arpc_pkg::ST_AGE || state == arpc_pkg::ST_AGE_WAIT) begin
          if (entry_valid[vcheck_ix] && age > {16'd0, cache_timeout})
            entry_valid[vcheck_ix] <= 1'b0;
        end else begin
          if (entry_valid[vcheck_ix] && c_rip == ((cmd == arpc_pkg::CMD_TICK) ? p_rip : ip)) begin
            c_found <= 1'b1;
            hit_mac <= c_rmac;
          end
        end
      end
      if (pvcheck && !p_found && pending_valid[pvcheck_ix] && p_rip == ip) begin
        p_found <= 1'b1;
        p_hitix <= pvcheck_ix;
      end
    end
  end

endmodule

// ----- sv/arpc_checker.sv -----
module arpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [2:0] kind,
  input logic       hit,
  input logic       last
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy did not rise after a request");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy) else $error("busy held with last result");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == arpc_pkg::KIND_DONE |-> last)
    else $error("tick done without last");

  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && hit |-> (kind == arpc_pkg::KIND_LOOKUP || kind == arpc_pkg::KIND_RESOLVED))
    else $error("hit on wrong kind");

endmodule

bind arp_cache_with_request_retry arpc_checker u_arpc_checker (
  .clk, .rst, .start, .busy, .result_valid, .kind, .hit, .last
);
